[sv/comment_skipping_integer_token_scanner_defines.svh]
`ifndef COMMENT_SKIPPING_INTEGER_TOKEN_SCANNER_DEFINES_SVH
`define COMMENT_SKIPPING_INTEGER_TOKEN_SCANNER_DEFINES_SVH

// Combinational implication checked at every clock edge.
`define CSITS_ASSERT_NOW(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Implication checked at the clock edge after the condition.
`define CSITS_ASSERT_NEXT(lbl, clk, rst, cond, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[sv/csits_pkg.sv]
`default_nettype none

package csits_pkg;

   localparam int CHAR_BITS = 16;

   localparam logic [CHAR_BITS-1:0] CH_NUL   = CHAR_BITS'(0);
   localparam logic [CHAR_BITS-1:0] CH_TAB   = CHAR_BITS'(9);
   localparam logic [CHAR_BITS-1:0] CH_CR    = CHAR_BITS'(13);
   localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(32);
   localparam logic [CHAR_BITS-1:0] CH_STAR  = CHAR_BITS'(42);
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = CHAR_BITS'(43);
   localparam logic [CHAR_BITS-1:0] CH_MINUS = CHAR_BITS'(45);
   localparam logic [CHAR_BITS-1:0] CH_SLASH = CHAR_BITS'(47);
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CH_NINE  = CHAR_BITS'(57);
   localparam logic [CHAR_BITS-1:0] CH_EQUAL = CHAR_BITS'(61);
   localparam logic [CHAR_BITS-1:0] CH_UP_A  = CHAR_BITS'(65);
   localparam logic [CHAR_BITS-1:0] CH_UP_F  = CHAR_BITS'(70);
   localparam logic [CHAR_BITS-1:0] CH_UP_X  = CHAR_BITS'(88);
   localparam logic [CHAR_BITS-1:0] CH_LO_A  = CHAR_BITS'(97);
   localparam logic [CHAR_BITS-1:0] CH_LO_F  = CHAR_BITS'(102);
   localparam logic [CHAR_BITS-1:0] CH_LO_X  = CHAR_BITS'(120);

   localparam logic [1:0] KIND_DEC = 2'd0;
   localparam logic [1:0] KIND_HEX = 2'd1;
   localparam logic [1:0] KIND_EQ  = 2'd2;
   localparam logic [1:0] KIND_END = 2'd3;

   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [35:0] MAG_CAP   = 36'h0_8000_0000;

   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_BETWEEN    = 3'd0,
      MODE_SLASH      = 3'd1,
      MODE_LINE       = 3'd2,
      MODE_LINE_SKIP  = 3'd3,
      MODE_BLOCK      = 3'd4,
      MODE_BLOCK_STAR = 3'd5,
      MODE_TOKEN      = 3'd6,
      MODE_LEAD_ZERO  = 3'd7
   } mode_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;  // two's complement
      logic        last;
   } word_type;

   // results of one character: count (0..2), then the words in order
   typedef struct packed {
      logic [1:0] count;
      word_type   first;
      word_type   second;
   } step_out_type;

endpackage

`default_nettype wire

[sv/comment_skipping_integer_token_scanner.sv]
// Scans a text one character per word and sends one result word per token: decimal
// (saturating, optional sign), hex after 0x/0X, -1 for a token that starts with '=',
// and an end word when a zero character arrives. Whitespace, // line comments and
// /* */ block comments are skipped. A character is registered, the scanner state and
// any result words are formed from it in the next cycle, and the words go into an
// 8-word output queue, so the result of a token passes the input register and then
// the queue before it is shown on rsp_tvalid, and may wait behind older words there.
// A new character is taken every cycle while the queue has room for the words of the
// character in the input register plus two more; req_tready drops only when the
// consumer falls behind. The end character of a text with an open token gives two
// words, the token's (tlast low) then the end word (tlast high).
`default_nettype none

module comment_skipping_integer_token_scanner (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [csits_pkg::CHAR_BITS-1:0] req_tdata,  // [15:0] char_code
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [31:0]                          rsp_tdata,  // [31:0] token_value
   output logic [1:0]                           rsp_tuser,  // [1:0] token_kind
   output logic                                 rsp_tlast
);
   import csits_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0]  in_char_ff;
   logic                  accept;
   logic [CNT_W-1:0]      queue_count;
   logic [CNT_W-1:0]      room_need;
   step_out_type          step_out;
   word_type              head;

   assign room_need   = queue_count + (in_valid_ff ? CNT_W'(2) : CNT_W'(0));
   assign req_tready  = (room_need <= CNT_W'(FIFO_DEPTH - 2));
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_tdata;
      end
   end

   csits_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (in_valid_ff),
      .step_char  (in_char_ff),
      .step_out   (step_out)
   );

   csits_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (step_out),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .count      (queue_count)
   );

   assign rsp_tdata = head.value;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

[sv/csits_fifo.sv]
`default_nettype none

module csits_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire csits_pkg::step_out_type    push,
   input  wire logic                       pop_ready,
   output logic                            head_valid,
   output csits_pkg::word_type             head,
   output logic [csits_pkg::CNT_W-1:0]     count
);
   import csits_pkg::*;

   word_type               mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       wr_next;
   logic                   pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign pop        = head_valid && pop_ready;
   assign wr_next    = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

[sv/csits_core.sv]
`default_nettype none

module csits_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step_valid,
   input  wire logic [csits_pkg::CHAR_BITS-1:0] step_char,
   output csits_pkg::step_out_type              step_out
);
   import csits_pkg::*;

   mode_type     mode_ff, mode_in;
   logic [1:0]   kind_ff, kind_in;
   logic [31:0]  acc_ff, acc_in;
   logic         neg_ff, neg_in;
   logic         stop_ff, stop_in;

   logic         is_end, is_space, is_slash, is_star, is_digit, is_hex_alpha;
   logic         token_open;
   logic [35:0]  mac;
   logic [31:0]  dec_next;
   logic [31:0]  tok_value;

   assign is_end       = (step_char == CH_NUL);
   assign is_space     = (step_char == CH_SPACE) ||
                         ((step_char >= CH_TAB) && (step_char <= CH_CR));
   assign is_slash     = (step_char == CH_SLASH);
   assign is_star      = (step_char == CH_STAR);
   assign is_digit     = (step_char >= CH_ZERO) && (step_char <= CH_NINE);
   assign is_hex_alpha = ((step_char >= CH_LO_A) && (step_char <= CH_LO_F)) ||
                         ((step_char >= CH_UP_A) && (step_char <= CH_UP_F));
   assign token_open   = (mode_ff == MODE_TOKEN) || (mode_ff == MODE_LEAD_ZERO) ||
                         (mode_ff == MODE_SLASH);

   // acc*10 + digit; digit value of '0'..'9' is the low nibble
   assign mac      = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                     {32'd0, step_char[3:0]};
   assign dec_next = (mac >= MAG_CAP) ? MAG_CAP[31:0] : mac[31:0];

   always_comb begin
      case (kind_ff)
         KIND_EQ:  tok_value = '1;
         KIND_HEX: tok_value = acc_ff;
         default: begin
            if (neg_ff) begin
               tok_value = 32'd0 - acc_ff;
            end else begin
               tok_value = acc_ff[31] ? VALUE_MAX : acc_ff;
            end
         end
      endcase
   end

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (step_valid) begin
         if (is_end) begin
            mode_in = MODE_BETWEEN;
         end else begin
            case (mode_ff)
               MODE_BETWEEN: begin
                  if (is_slash) begin
                     mode_in = MODE_SLASH;
                  end else if (step_char == CH_ZERO) begin
                     mode_in = MODE_LEAD_ZERO;
                  end else if (!is_space) begin
                     mode_in = MODE_TOKEN;
                  end
               end
               MODE_SLASH: begin
                  if (is_slash) begin
                     mode_in = MODE_LINE;
                  end else if (is_star) begin
                     mode_in = MODE_BLOCK;
                  end else if (is_space) begin
                     mode_in = MODE_BETWEEN;
                  end else begin
                     mode_in = MODE_TOKEN;
                  end
               end
               MODE_LINE: begin
                  if (step_char == CH_CR) begin
                     mode_in = MODE_LINE_SKIP;
                  end
               end
               MODE_LINE_SKIP: mode_in = MODE_BETWEEN;
               MODE_BLOCK: begin
                  if (is_star) begin
                     mode_in = MODE_BLOCK_STAR;
                  end
               end
               MODE_BLOCK_STAR: begin
                  if (is_slash) begin
                     mode_in = MODE_BETWEEN;
                  end else if (!is_star) begin
                     mode_in = MODE_BLOCK;
                  end
               end
               MODE_TOKEN, MODE_LEAD_ZERO: begin
                  mode_in = is_space ? MODE_BETWEEN : MODE_TOKEN;
               end
               default: mode_in = MODE_BETWEEN;
            endcase
         end
      end
   end

   // token datapath
   always_comb begin
      kind_in = kind_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      stop_in = stop_ff;
      if (step_valid) begin
         if (is_end) begin
            kind_in = KIND_DEC;
            acc_in  = '0;
            neg_in  = 1'b0;
            stop_in = 1'b0;
         end else begin
            case (mode_ff)
               MODE_BETWEEN: begin
                  if (!is_space) begin
                     kind_in = KIND_DEC;
                     acc_in  = '0;
                     neg_in  = 1'b0;
                     stop_in = 1'b0;
                     if (step_char == CH_EQUAL) begin
                        kind_in = KIND_EQ;
                        stop_in = 1'b1;
                     end else if (step_char == CH_MINUS) begin
                        neg_in = 1'b1;
                     end else if (is_digit) begin
                        acc_in = {28'd0, step_char[3:0]};
                     end else if (!is_slash && (step_char != CH_PLUS)) begin
                        stop_in = 1'b1;
                     end
                  end
               end
               MODE_SLASH: begin
                  if (is_slash || is_star || is_space) begin
                     kind_in = KIND_DEC;
                     acc_in  = '0;
                     neg_in  = 1'b0;
                     stop_in = 1'b0;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
               MODE_TOKEN, MODE_LEAD_ZERO: begin
                  if (is_space) begin
                     kind_in = KIND_DEC;
                     acc_in  = '0;
                     neg_in  = 1'b0;
                     stop_in = 1'b0;
                  end else if ((mode_ff == MODE_LEAD_ZERO) &&
                               ((step_char == CH_LO_X) || (step_char == CH_UP_X))) begin
                     kind_in = KIND_HEX;
                     acc_in  = '0;
                  end else if (!stop_ff && (kind_ff == KIND_HEX)) begin
                     if (is_digit) begin
                        acc_in = {acc_ff[27:0], step_char[3:0]};
                     end else if (is_hex_alpha) begin
                        acc_in = {acc_ff[27:0], step_char[3:0] + 4'd9};
                     end else begin
                        stop_in = 1'b1;
                     end
                  end else if (!stop_ff && (kind_ff == KIND_DEC)) begin
                     if (is_digit) begin
                        acc_in = dec_next;
                     end else begin
                        stop_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // result words
   always_comb begin
      step_out = '0;
      if (step_valid) begin
         if (is_end) begin
            if (token_open) begin
               step_out.count  = 2'd2;
               step_out.first  = '{kind: kind_ff, value: tok_value, last: 1'b0};
               step_out.second = '{kind: KIND_END, value: 32'd0, last: 1'b1};
            end else begin
               step_out.count = 2'd1;
               step_out.first = '{kind: KIND_END, value: 32'd0, last: 1'b1};
            end
         end else if (is_space && token_open) begin
            // a lone slash closes as decimal zero; its token state is clear
            step_out.count = 2'd1;
            step_out.first = '{kind: kind_ff, value: tok_value, last: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         kind_ff <= KIND_DEC;
         acc_ff  <= '0;
         neg_ff  <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         kind_ff <= kind_in;
         acc_ff  <= acc_in;
         neg_ff  <= neg_in;
         stop_ff <= stop_in;
      end
   end

endmodule

`default_nettype wire

[sv/csits_checker.sv]
`default_nettype none

`include "comment_skipping_integer_token_scanner_defines.svh"

module csits_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [31:0]                     rsp_tdata,
   input wire logic [1:0]                      rsp_tuser,
   input wire logic                            rsp_tlast
);
   import csits_pkg::*;

   logic        rsp_wait;
   logic        rsp_take;
   logic [34:0] rsp_word;

   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign rsp_word = {rsp_tuser, rsp_tdata, rsp_tlast};

   // a stalled word stays put
   `CSITS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait,
      rsp_tvalid && $stable(rsp_word), "stalled result word changed")

   // end word is last and carries zero
   `CSITS_ASSERT_NOW(a_end_word, clock, reset, rsp_tvalid && (rsp_tuser == KIND_END),
      rsp_tlast && (rsp_tdata == 32'd0), "end word malformed")

   // a token word without tlast is the one before an end word, queued with it
   `CSITS_ASSERT_NEXT(a_end_follows, clock, reset, rsp_take && !rsp_tlast,
      rsp_tvalid && (rsp_tuser == KIND_END), "end word missing after open token")

   // equals marker always reads as -1
   `CSITS_ASSERT_NOW(a_eq_value, clock, reset, rsp_tvalid && (rsp_tuser == KIND_EQ),
      rsp_tdata == 32'hFFFF_FFFF, "equals marker value not -1")

   // input only stalls while the queue holds words
   `CSITS_ASSERT_NOW(a_stall_queue, clock, reset, !req_tready, rsp_tvalid,
      "input stalled with empty queue")

endmodule

bind comment_skipping_integer_token_scanner csits_checker u_csits_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[sim/comment_skipping_integer_token_scanner_test.sv]
module comment_skipping_integer_token_scanner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csits_pkg::*;

   localparam int PERIOD      = 8;
   localparam int RAND_GOAL   = 800;
   localparam int STALL_LIMIT = 5000;
   localparam word_type NO_WORD = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // [15:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] token_value
   logic [1:0]  rsp_tuser;        // [1:0] token_kind
   logic        rsp_tlast;

   comment_skipping_integer_token_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(PERIOD / 2) clock = ~clock;

   // scanner state as the predictor sees it
   mode_type    scan_state = MODE_BETWEEN;
   logic [1:0]  tok_kind   = KIND_DEC;
   logic [31:0] tok_acc    = '0;
   logic        tok_neg    = 1'b0;
   logic        tok_stop   = 1'b0;

   word_type    pending_words [$];
   word_type    want_word;
   int          mismatches     = 0;
   int          words_checked  = 0;
   int          chars_sent     = 0;
   int          chars_scanned  = 0;
   int          send_idle_pct  = 35;
   int          rcv_idle_pct   = 65;
   int          stall_cycles   = 0;

   typedef struct {
      logic [15:0] ch;
      int          typed_n;  // 0: predictor decides
      word_type    t0;
      word_type    t1;
   } dir_row_type;

   dir_row_type dir_rows [$];
   logic [15:0] text_q [$];

   function automatic bit is_blank(logic [15:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void clear_token();
      tok_kind = KIND_DEC;
      tok_acc  = '0;
      tok_neg  = 1'b0;
      tok_stop = 1'b0;
   endfunction

   function automatic logic [31:0] open_value();
      if (tok_kind == KIND_EQ) return '1;
      if (tok_kind == KIND_HEX) return tok_acc;
      if (tok_neg) return -tok_acc;
      return (tok_acc > VALUE_MAX) ? VALUE_MAX : tok_acc;
   endfunction

   function automatic void add_dec_digit(logic [15:0] c);
      logic [63:0] grown;
      if (tok_stop) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         grown   = 64'(tok_acc) * 64'd10 + 64'(c - CH_ZERO);
         tok_acc = (grown >= 64'h8000_0000) ? 32'h8000_0000 : grown[31:0];
      end else begin
         tok_stop = 1'b1;
      end
   endfunction

   function automatic void add_hex_digit(logic [15:0] c);
      logic [3:0] nib;
      if (tok_stop) return;
      if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
      else if (c >= CH_LO_A && c <= CH_LO_F) nib = 4'(c - CH_LO_A + 16'd10);
      else if (c >= CH_UP_A && c <= CH_UP_F) nib = 4'(c - CH_UP_A + 16'd10);
      else begin
         tok_stop = 1'b1;
         return;
      end
      tok_acc = {tok_acc[27:0], nib};
   endfunction

   function automatic void start_token(logic [15:0] c);
      clear_token();
      scan_state = MODE_TOKEN;
      if (c == CH_EQUAL) begin
         tok_kind = KIND_EQ;
         tok_stop = 1'b1;
      end else if (c == CH_MINUS) begin
         tok_neg = 1'b1;
      end else if (c == CH_ZERO) begin
         scan_state = MODE_LEAD_ZERO;
      end else if (c != CH_PLUS) begin
         add_dec_digit(c);
      end
   endfunction

   // advances the scanner by one character, returns how many result words it makes
   function automatic int scan_char(input logic [15:0] c, output word_type w0,
                                    output word_type w1);
      int n;
      n  = 0;
      w0 = NO_WORD;
      w1 = NO_WORD;
      if (c == CH_NUL) begin
         if (scan_state == MODE_TOKEN || scan_state == MODE_LEAD_ZERO ||
             scan_state == MODE_SLASH) begin
            w0 = {tok_kind, open_value(), 1'b0};
            n  = 1;
         end
         if (n == 0) w0 = {KIND_END, 32'd0, 1'b1};
         else w1 = {KIND_END, 32'd0, 1'b1};
         scan_state = MODE_BETWEEN;
         clear_token();
         return n + 1;
      end
      case (scan_state)
         MODE_BETWEEN: begin
            if (c == CH_SLASH) begin
               clear_token();
               scan_state = MODE_SLASH;
            end else if (!is_blank(c)) begin
               start_token(c);
            end
         end
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               clear_token();
               scan_state = MODE_LINE;
            end else if (c == CH_STAR) begin
               clear_token();
               scan_state = MODE_BLOCK;
            end else if (is_blank(c)) begin
               w0 = {KIND_DEC, 32'd0, 1'b1};
               n  = 1;
               clear_token();
               scan_state = MODE_BETWEEN;
            end else begin
               // lone slash turns into a digitless token
               tok_stop   = 1'b1;
               scan_state = MODE_TOKEN;
            end
         end
         MODE_LINE: begin
            if (c == CH_CR) scan_state = MODE_LINE_SKIP;
         end
         MODE_LINE_SKIP: begin
            scan_state = MODE_BETWEEN;
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) scan_state = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) scan_state = MODE_BETWEEN;
            else if (c != CH_STAR) scan_state = MODE_BLOCK;
         end
         default: begin
            if (is_blank(c)) begin
               w0 = {tok_kind, open_value(), 1'b1};
               n  = 1;
               clear_token();
               scan_state = MODE_BETWEEN;
            end else if (scan_state == MODE_LEAD_ZERO) begin
               scan_state = MODE_TOKEN;
               if (c == CH_LO_X || c == CH_UP_X) begin
                  tok_kind = KIND_HEX;
                  tok_acc  = '0;
               end else begin
                  add_dec_digit(c);
               end
            end else if (tok_kind == KIND_HEX) begin
               add_hex_digit(c);
            end else if (tok_kind == KIND_DEC) begin
               add_dec_digit(c);
            end
         end
      endcase
      return n;
   endfunction

   function automatic void add_row(logic [15:0] ch, int typed_n, word_type t0,
                                   word_type t1);
      dir_row_type r;
      r.ch      = ch;
      r.typed_n = typed_n;
      r.t0      = t0;
      r.t1      = t1;
      dir_rows.push_back(r);
   endfunction

   function automatic logic [15:0] pick_from(string s);
      return 16'(s[$urandom_range(s.len() - 1)]);
   endfunction

   function automatic logic [15:0] random_blank();
      return ($urandom_range(2) == 0) ? CH_SPACE : 16'($urandom_range(13, 9));
   endfunction

   task automatic send_char(input logic [15:0] c, input int typed_n, input word_type t0,
                            input word_type t1);
      int       gap;
      int       n;
      word_type w0;
      word_type w1;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (c == CH_NUL || !(scan_state == MODE_LINE || scan_state == MODE_LINE_SKIP ||
          scan_state == MODE_BLOCK || scan_state == MODE_BLOCK_STAR ||
          (scan_state == MODE_BETWEEN && is_blank(c))))
         chars_scanned++;
      n = scan_char(c, w0, w1);
      if (typed_n > 0) begin
         n  = typed_n;
         w0 = t0;
         w1 = t1;
      end
      if (n > 0) pending_words.push_back(w0);
      if (n > 1) pending_words.push_back(w1);
      chars_sent++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected result word: kind %0d value %0d last %0d",
                   rsp_tuser, $signed(rsp_tdata), rsp_tlast);
            mismatches++;
         end else begin
            want_word = pending_words.pop_front();
            words_checked++;
            if (rsp_tuser !== want_word.kind) begin
               $error("token_kind: expected %0d, got %0d", want_word.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata !== want_word.value) begin
               $error("token_value: expected %0d, got %0d",
                      $signed(want_word.value), $signed(rsp_tdata));
               mismatches++;
            end
            if (rsp_tlast !== want_word.last) begin
               $error("last: expected %0d, got %0d", want_word.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int base;
      int len;
      int r;

      // end of text on a fresh scanner
      add_row(CH_NUL, 1, {KIND_END, 32'd0, 1'b1}, NO_WORD);
      add_row(CH_EQUAL, 0, NO_WORD, NO_WORD);
      add_row(CH_SPACE, 1, {KIND_EQ, 32'hFFFF_FFFF, 1'b1}, NO_WORD);
      // line comment, CR, then the swallowed char after it
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_CR, 0, NO_WORD, NO_WORD);
      add_row(16'hFFFF, 0, NO_WORD, NO_WORD);
      // "/*/" stays open, "*/" closes
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_STAR, 0, NO_WORD, NO_WORD);
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_STAR, 0, NO_WORD, NO_WORD);
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      // lone slash
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_SPACE, 1, {KIND_DEC, 32'd0, 1'b1}, NO_WORD);
      // hex, slash inside the token stops the digits
      add_row(CH_ZERO, 0, NO_WORD, NO_WORD);
      add_row(CH_UP_X, 0, NO_WORD, NO_WORD);
      add_row(CH_UP_F, 0, NO_WORD, NO_WORD);
      add_row(CH_SLASH, 0, NO_WORD, NO_WORD);
      add_row(CH_TAB, 0, NO_WORD, NO_WORD);
      // negative overflow closed by end of text
      add_row(CH_MINUS, 0, NO_WORD, NO_WORD);
      repeat (10) add_row(CH_NINE, 0, NO_WORD, NO_WORD);
      add_row(CH_NUL, 2, {KIND_DEC, 32'h8000_0000, 1'b0}, {KIND_END, 32'd0, 1'b1});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_char(dir_rows[i].ch, dir_rows[i].typed_n, dir_rows[i].t0, dir_rows[i].t1);

      base = chars_sent;
      for (int ph = 0; ph < 3; ph++) begin
         // hold off until the scanner has drained
         req_tvalid <= 1'b0;
         do @(posedge clock); while (pending_words.size() != 0);
         send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
         rcv_idle_pct  = (ph == 0) ? 65 : (ph == 1) ? 35 : 0;
         while (chars_sent < base + (ph + 1) * RAND_GOAL / 3) begin
            text_q.delete();
            r = $urandom_range(99);
            if (r < 35) begin
               // decimal, sometimes long enough to saturate
               r = $urandom_range(3);
               if (r == 0) text_q.push_back(CH_MINUS);
               else if (r == 1) text_q.push_back(CH_PLUS);
               len = ($urandom_range(3) == 0) ? $urandom_range(12, 9) : $urandom_range(5, 1);
               repeat (len) text_q.push_back(pick_from("0123456789"));
               if ($urandom_range(5) == 0) text_q.push_back(pick_from("a/x-9"));
            end else if (r < 50) begin
               text_q.push_back(CH_ZERO);
               text_q.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
               len = ($urandom_range(3) == 0) ? $urandom_range(11, 8) : $urandom_range(4);
               repeat (len) text_q.push_back(pick_from("0123456789abcdefABCDEF"));
               if ($urandom_range(4) == 0) text_q.push_back(pick_from("gG/x7"));
            end else if (r < 55) begin
               text_q.push_back(CH_EQUAL);
               repeat ($urandom_range(2)) text_q.push_back(pick_from("=5a"));
            end else if (r < 62) begin
               text_q.push_back(CH_SLASH);
               text_q.push_back(CH_SLASH);
               repeat ($urandom_range(5)) text_q.push_back(pick_from("ab/* 7"));
               text_q.push_back(CH_CR);
               text_q.push_back(16'($urandom_range(65535, 1)));
            end else if (r < 70) begin
               text_q.push_back(CH_SLASH);
               text_q.push_back(CH_STAR);
               repeat ($urandom_range(6)) text_q.push_back(pick_from("a/**/ 3"));
               text_q.push_back(CH_STAR);
               text_q.push_back(CH_SLASH);
            end else if (r < 75) begin
               text_q.push_back(CH_SLASH);
               repeat ($urandom_range(2)) text_q.push_back(pick_from("5/a-"));
            end else if (r < 85) begin
               repeat ($urandom_range(4, 1)) text_q.push_back(16'($urandom_range(65535)));
            end else if (r < 92) begin
               text_q.push_back(CH_NUL);
            end else begin
               text_q.push_back(CH_ZERO);
               repeat ($urandom_range(3)) text_q.push_back(pick_from("0123456789z"));
            end
            repeat ($urandom_range(3)) text_q.push_back(random_blank());
            foreach (text_q[i]) send_char(text_q[i], 0, NO_WORD, NO_WORD);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("sent %0d characters (%0d outside blanks and comments) through three idle mixes",
               chars_sent, chars_scanned);
      $display("checked %0d result words, %0d failures", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
